### rtl/core/pwwr_pkg.sv
// Package for the pulse width word receiver: register codes, reset values,
// event codes and the structs passed between the receiver's modules.
// No dependencies.
`timescale 1ns / 1ps

package pwwr_pkg;

  localparam int LEN_W          = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int CNT_W          = 6;
  localparam int EV_W           = 3;
  localparam int OUT_WORD_W     = 32;
  localparam int DEF_WORD_BITS  = 32;

  localparam logic [LEN_W-1:0] LEN_MAX   = 16'hFFFF;
  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  localparam logic [LEN_W-1:0] RST_ZERO_TIME   = 16'h0200;
  localparam logic [LEN_W-1:0] RST_ONE_TIME    = 16'h0400;
  localparam logic [LEN_W-1:0] RST_BREAK_TIME  = 16'h0800;
  localparam logic [LEN_W-1:0] RST_SYNC_TIME   = 16'h1000;
  localparam logic [LEN_W-1:0] RST_TOLERANCE   = 16'h0080;
  localparam logic [LEN_W-1:0] RST_MIN_PRESS   = 16'h0080;
  localparam logic [LEN_W-1:0] RST_SHORT_LIMIT = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_TIME   = 3'd0,
    CFG_ONE_TIME    = 3'd1,
    CFG_BREAK_TIME  = 3'd2,
    CFG_SYNC_TIME   = 3'd3,
    CFG_TOLERANCE   = 3'd4,
    CFG_MASTER_MODE = 3'd5,
    CFG_MIN_PRESS   = 3'd6,
    CFG_SHORT_LIMIT = 3'd7
  } cfg_idx_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 3'd0,
    EV_WORD  = 3'd1,
    EV_SYNC  = 3'd2,
    EV_SHORT = 3'd3,
    EV_LONG  = 3'd4
  } ev_t;

  typedef struct packed {
    logic [LEN_W-1:0] zero_time;
    logic [LEN_W-1:0] one_time;
    logic [LEN_W-1:0] break_time;
    logic [LEN_W-1:0] sync_time;
    logic [LEN_W-1:0] tolerance;
    logic             master_mode;
    logic [LEN_W-1:0] min_press;
    logic [LEN_W-1:0] short_press_limit;
  } cfg_t;

  // Classification of one pulse; at most one of take_bit, brk and sync is
  // set, and bit_one only qualifies take_bit.
  typedef struct packed {
    logic take_bit;
    logic bit_one;
    logic brk;
    logic sync;
    ev_t  press_ev;
  } dec_t;

endpackage

### rtl/core/pwwr_if.sv
// Handshake interfaces for the pulse width word receiver's input and
// result channels. Depends on pwwr_pkg for field widths.
`timescale 1ns / 1ps

interface pwwr_in_if import pwwr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] pulse_length;
  logic             timer_overflow;

  modport source (output valid, output pulse_length, output timer_overflow, input ready);
  modport sink   (input valid, input pulse_length, input timer_overflow, output ready);
endinterface

interface pwwr_out_if import pwwr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [EV_W-1:0]       event_res;
  logic [OUT_WORD_W-1:0] word;

  modport source (output valid, output event_res, output word, input ready);
  modport sink   (input valid, input event_res, input word, output ready);
endinterface

### rtl/core/pwwr_cfg_regs.sv
// Configuration register file of the pulse width word receiver.
// Depends on pwwr_pkg for register codes and reset values.
`timescale 1ns / 1ps

module pwwr_cfg_regs import pwwr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ZERO_TIME:   cfg_nxt.zero_time         = cfg_wdata;
        CFG_ONE_TIME:    cfg_nxt.one_time          = cfg_wdata;
        CFG_BREAK_TIME:  cfg_nxt.break_time        = cfg_wdata;
        CFG_SYNC_TIME:   cfg_nxt.sync_time         = cfg_wdata;
        CFG_TOLERANCE:   cfg_nxt.tolerance         = cfg_wdata;
        CFG_MASTER_MODE: cfg_nxt.master_mode       = cfg_wdata[0];
        CFG_MIN_PRESS:   cfg_nxt.min_press         = cfg_wdata;
        CFG_SHORT_LIMIT: cfg_nxt.short_press_limit = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_time         <= RST_ZERO_TIME;
      cfg_r.one_time          <= RST_ONE_TIME;
      cfg_r.break_time        <= RST_BREAK_TIME;
      cfg_r.sync_time         <= RST_SYNC_TIME;
      cfg_r.tolerance         <= RST_TOLERANCE;
      cfg_r.master_mode       <= 1'b0;
      cfg_r.min_press         <= RST_MIN_PRESS;
      cfg_r.short_press_limit <= RST_SHORT_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/pwwr_decode.sv
// Pulse classifier: window tests in receive mode, press classes in master
// mode. Purely combinational. Depends on pwwr_pkg.
`timescale 1ns / 1ps

module pwwr_decode import pwwr_pkg::*; (
  input  cfg_t             cfg,
  input  logic [LEN_W-1:0] pulse_length,
  input  logic             timer_overflow,
  output dec_t             dec
);

  logic [LEN_W-1:0] len;
  logic             in_zero;
  logic             in_one;
  logic             in_break;
  logic             in_sync;

  // Bounds are exclusive and computed one bit wider, so they never wrap.
  function automatic logic in_window(input logic [LEN_W-1:0] l,
                                     input logic [LEN_W-1:0] nom,
                                     input logic [LEN_W-1:0] tol);
    logic [LEN_W:0] lo_side;
    logic [LEN_W:0] hi_side;
    lo_side = {1'b0, l} + {1'b0, tol};
    hi_side = {1'b0, nom} + {1'b0, tol};
    return (lo_side > {1'b0, nom}) && ({1'b0, l} < hi_side);
  endfunction

  assign len      = timer_overflow ? LEN_MAX : pulse_length;
  assign in_zero  = in_window(len, cfg.zero_time,  cfg.tolerance);
  assign in_one   = in_window(len, cfg.one_time,   cfg.tolerance);
  assign in_break = in_window(len, cfg.break_time, cfg.tolerance);
  assign in_sync  = in_window(len, cfg.sync_time,  cfg.tolerance);

  always_comb begin
    dec = '{take_bit: 1'b0, bit_one: 1'b0, brk: 1'b0, sync: 1'b0, press_ev: EV_NONE};
    if (cfg.master_mode) begin
      if (len > cfg.min_press && len <= cfg.short_press_limit) begin
        dec.press_ev = EV_SHORT;
      end else if (len > cfg.short_press_limit) begin
        dec.press_ev = EV_LONG;
      end
    end else if (in_zero) begin
      dec.take_bit = 1'b1;
    end else if (in_one) begin
      dec.take_bit = 1'b1;
      dec.bit_one  = 1'b1;
    end else if (in_break) begin
      dec.brk = 1'b1;
    end else if (in_sync) begin
      dec.sync = 1'b1;
    end
  end

endmodule

### rtl/core/pwwr_word_acc.sv
// Word accumulator: shift register and saturating bit count, and the
// result event and word for each classified pulse. Depends on pwwr_pkg.
`timescale 1ns / 1ps

module pwwr_word_acc import pwwr_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  dec_t                  dec,
  output ev_t                   ev,
  output logic [OUT_WORD_W-1:0] word
);

  localparam int EXT_W = (WORD_BITS > OUT_WORD_W) ? WORD_BITS : OUT_WORD_W;
  localparam logic [CNT_W:0] FULL_COUNT = (CNT_W + 1)'(WORD_BITS);

  logic [WORD_BITS-1:0] shift_r;
  logic [WORD_BITS-1:0] shift_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [EXT_W-1:0]     shift_ext;

  assign shift_ext = EXT_W'(shift_r);

  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    ev        = dec.press_ev;
    word      = '0;
    if (dec.take_bit) begin
      // New bits enter at the top; the oldest bit ends up at bit 0.
      shift_nxt = {dec.bit_one, shift_r[WORD_BITS-1:1]};
      if (cnt_r != COUNT_MAX) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else if (dec.brk) begin
      if ({1'b0, cnt_r} == FULL_COUNT) begin
        ev   = EV_WORD;
        word = shift_ext[OUT_WORD_W-1:0];
      end
      shift_nxt = '0;
      cnt_nxt   = '0;
    end else if (dec.sync) begin
      ev        = EV_SYNC;
      shift_nxt = '0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/core/pulse_width_word_receiver.sv
// Pulse width word receiver, top level: input register, classifier, word
// accumulator and result register. Depends on pwwr_pkg, pwwr_if and the
// pwwr_cfg_regs, pwwr_decode and pwwr_word_acc modules.
//
// Usage: each item on in_ch carries one measured high-pulse length and a
// timer overflow flag; each accepted item yields exactly one item on
// out_ch with an event code and, for a received word, the word itself.
// Both channels use valid/ready and an item moves when both are high.
// The cfg_* port writes one register per cycle at cfg_we; write it only
// while no item is in flight.
// An accepted item is held in the input register and moves on into the
// result register once that is free, where the receiver can take it.
// Throughput: one item per cycle while out_ch is ready; the classifier
// and the shift step both fit between the input and result registers.
// A stalled receiver holds the result; the input register keeps taking
// one more item, after which in_ch.ready drops until out_ch drains.
// Reset (synchronous, rst_n low) empties both registers, clears the
// word and bit count, and loads the register defaults.
`timescale 1ns / 1ps

module pulse_width_word_receiver import pwwr_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pwwr_in_if.sink               in_ch,
  pwwr_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                  cfg;
  dec_t                  dec;
  ev_t                   acc_ev;
  logic [OUT_WORD_W-1:0] acc_word;

  logic                  s1_v_r;
  logic [LEN_W-1:0]      s1_len_r;
  logic                  s1_ovf_r;
  logic                  out_v_r;
  ev_t                   out_ev_r;
  logic [OUT_WORD_W-1:0] out_word_r;

  logic                  adv;
  logic                  in_ready;
  logic                  step;

  assign adv      = !out_v_r || out_ch.ready;
  assign in_ready = !s1_v_r || adv;
  assign step     = s1_v_r && adv;

  pwwr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pwwr_decode u_decode (
    .cfg            (cfg),
    .pulse_length   (s1_len_r),
    .timer_overflow (s1_ovf_r),
    .dec            (dec)
  );

  pwwr_word_acc #(
    .WORD_BITS (WORD_BITS)
  ) u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .dec   (dec),
    .ev    (acc_ev),
    .word  (acc_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_len_r <= in_ch.pulse_length;
      s1_ovf_r <= in_ch.timer_overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_ev_r   <= acc_ev;
      out_word_r <= acc_word;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_v_r;
  assign out_ch.event_res = out_ev_r;
  assign out_ch.word      = out_word_r;

`ifndef SYNTH
  // Only a received word carries a nonzero word field.
  a_word_only_on_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ev_r != EV_WORD) |-> (out_word_r == '0))
    else $error("word field nonzero without a word event");

  // An item leaving the input register always lands in the result register.
  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("item lost between input and result register");

  // Input is refused only when both registers are full and the output stalls.
  a_ready_low_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && out_v_r && !out_ch.ready))
    else $error("input refused while there was room");

  // A stalled result keeps its event code.
  a_stall_holds_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> $stable(out_ev_r))
    else $error("result changed while stalled");
`endif

endmodule
